FILE: sv/fft2d_pkg.sv
// ----------------------------------------------------------------------------
// fft2d_pkg
// Types, constants and helpers for the in-place 2-D radix-2 FFT block.
// ----------------------------------------------------------------------------
package fft2d_pkg;

  // default geometry and input sample width
  localparam int unsigned DefRows       = 64;
  localparam int unsigned DefCols       = 64;
  localparam int unsigned DefSampleBits = 16;

  // quarter-wave twiddle table geometry
  localparam int unsigned TwQuarter = 256;
  localparam int unsigned TwLog     = 9;   // log2 of the half-circle point count

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e               command;
    logic [11:0]        sample_index;
    logic signed [15:0] sample_real;
    logic signed [15:0] sample_imag;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_real;
    logic signed [31:0] result_imag;
    logic               run_done;
    logic               overflow_seen;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_PM_CHK,
    S_PM_RDQ,
    S_PM_WP,
    S_PM_WQ,
    S_BF_RDQ,
    S_BF_RDP,
    S_BF_M0,
    S_BF_M1,
    S_BF_M2,
    S_BF_M3,
    S_BF_M4,
    S_BF_WQ,
    S_BF_WP,
    S_DONE
  } state_e;

  typedef logic [15:0] tw_rom_t [0:TwQuarter];

  // sin table in Q1.15, from an eight-term series in Q2.30
  function automatic tw_rom_t build_tw_rom();
    tw_rom_t         rom;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          q;
    for (int k = 0; k <= TwQuarter; k++) begin
      x    = (longint'(k) * 64'd1686629713 + 64'd128) / 64'd256;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
      if (sum < 0) sum = 0;
      q = (sum + 16384) >>> 15;
      if (q > 32767) q = 32767;
      rom[k] = 16'(q);
    end
    return rom;
  endfunction

  localparam tw_rom_t TwRom = build_tw_rom();

  // saturation to 32 bits
  function automatic logic ovf32(input logic signed [34:0] v);
    return (v > 35'sd2147483647) || (v < -35'sd2147483648);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -35'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: sv/fft2d_ram.sv
// ----------------------------------------------------------------------------
// fft2d_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fft2d_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [0:Depth-1];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: sv/fft_2d_radix2_inplace.sv
// ----------------------------------------------------------------------------
// fft_2d_radix2_inplace
// In-place unnormalized 2-D complex FFT over a ROWS x COLS sample store.
// ----------------------------------------------------------------------------
// A write item gives no result; a read item goes through a registered store
// read and returns the element. A run item bit-reverses and transforms every
// row, then every column, one butterfly at a time through a single 32x17
// multiplier; the permutation checks each index and swaps it with its reverse
// when the index is the smaller, and the run ends with one answer. The single
// store port and the shared multiplier set the run time.
module fft_2d_radix2_inplace
  import fft2d_pkg::*;
#(
  parameter int unsigned ROWS        = DefRows,
  parameter int unsigned COLS        = DefCols,
  parameter int unsigned SAMPLE_BITS = DefSampleBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned LbR   = $clog2(ROWS);
  localparam int unsigned LbC   = $clog2(COLS);
  localparam int unsigned Aw    = LbR + LbC;
  localparam int unsigned Depth = ROWS * COLS;
  localparam int unsigned Pw    = (LbR > LbC) ? LbR : LbC;
  localparam int unsigned Sw    = $clog2(Pw + 1);
  localparam int unsigned Eb    = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
  localparam bit          SignX = (SAMPLE_BITS <= 16);

  state_e state_q, state_d;
  logic   inv_q;
  logic   sat_q, sat_d;
  logic   dim_q, dim_d;
  logic [Pw-1:0] line_q, line_d;
  logic [Pw-1:0] i_q, i_d;
  logic [Pw-1:0] k_q, k_d;
  logic [Sw-1:0] s_q, s_d;
  logic   out_valid_q, out_valid_d;
  out_item_t out_data_q, out_data_d;
  logic   oob_q, oob_d;

  // payload registers
  logic [63:0]        a_q, a_d;
  logic [63:0]        b_q, b_d;
  logic signed [48:0] prod_q, prod_d;
  logic signed [33:0] acc_q, acc_d;
  logic signed [31:0] tre_q, tre_d;
  logic signed [31:0] tim_q, tim_d;
  logic signed [16:0] wre_q, wre_d;
  logic signed [16:0] wim_q, wim_d;

  // store port
  logic          ram_we;
  logic [Aw-1:0] ram_waddr;
  logic [Aw-1:0] ram_raddr;
  logic [63:0]   ram_wdata;
  logic [63:0]   ram_rdata;

  fft2d_ram #(
    .Width(64),
    .Depth(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  logic in_fire;
  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // line geometry for the current dimension
  logic [Pw-1:0] pos_mask, line_last;
  logic [Sw-1:0] cur_bits;
  assign pos_mask  = dim_q ? Pw'(ROWS - 1) : Pw'(COLS - 1);
  assign line_last = dim_q ? Pw'(COLS - 1) : Pw'(ROWS - 1);
  assign cur_bits  = dim_q ? Sw'(LbR) : Sw'(LbC);

  function automatic logic [Aw-1:0] elem_addr(input logic d, input logic [Pw-1:0] ln,
                                               input logic [Pw-1:0] ps);
    logic [Aw-1:0] r;
    if (d) begin
      r = (Aw'(ps) << LbC) | Aw'(ln);
    end else begin
      r = (Aw'(ln) << LbC) | Aw'(ps);
    end
    return r;
  endfunction

  // bit reverse of the permutation index
  logic [Pw-1:0] rev_full, rev_i;
  always_comb begin
    for (int b = 0; b < Pw; b++) begin
      rev_full[b] = i_q[Pw-1-b];
    end
    rev_i = rev_full >> (Sw'(Pw) - cur_bits);
  end

  // butterfly positions within the line
  logic [Pw-1:0] half, jmask, j_idx, pos_p, pos_q;
  assign half  = Pw'(1) << s_q;
  assign jmask = half - Pw'(1);
  assign j_idx = k_q & jmask;
  assign pos_p = ((k_q & ~jmask) << 1) | j_idx;
  assign pos_q = pos_p | half;

  // twiddle lookup from the quarter-wave table
  logic [TwLog-1:0]   tw_k;
  logic signed [16:0] tw_c, tw_s;
  always_comb begin
    tw_k = TwLog'(10'(j_idx) << (TwLog - int'(s_q)));
    if (tw_k <= TwLog'(TwQuarter)) begin
      tw_c = $signed({1'b0, TwRom[TwLog'(TwLog'(TwQuarter) - tw_k)]});
      tw_s = $signed({1'b0, TwRom[tw_k]});
    end else begin
      tw_c = 17'sd0 - $signed({1'b0, TwRom[TwLog'(tw_k - TwLog'(TwQuarter))]});
      tw_s = $signed({1'b0, TwRom[TwLog'(10'd512 - 10'(tw_k))]});
    end
  end

  // rounding of the held product
  logic signed [48:0] psum;
  logic signed [33:0] rnd;
  assign psum = prod_q + 49'sd16384;
  assign rnd  = psum[48:15];

  // butterfly sums
  logic signed [34:0] t_full_re, t_full_im;
  logic signed [34:0] dif_re, dif_im, sum_re, sum_im;
  assign t_full_re = {acc_q[33], acc_q} - {rnd[33], rnd};
  assign t_full_im = {acc_q[33], acc_q} + {rnd[33], rnd};
  assign dif_re = {{3{a_q[63]}}, a_q[63:32]} - {{3{tre_q[31]}}, tre_q};
  assign dif_im = {{3{a_q[31]}}, a_q[31:0]}  - {{3{tim_q[31]}}, tim_q};
  assign sum_re = {{3{a_q[63]}}, a_q[63:32]} + {{3{tre_q[31]}}, tre_q};
  assign sum_im = {{3{a_q[31]}}, a_q[31:0]}  + {{3{tim_q[31]}}, tim_q};

  // sample extension
  logic [Eb-1:0] ext_re_src, ext_im_src;
  logic [31:0]   ext_re, ext_im;
  always_comb begin
    ext_re_src = in_data_i.sample_real[Eb-1:0];
    ext_im_src = in_data_i.sample_imag[Eb-1:0];
    ext_re     = 32'(ext_re_src);
    ext_im     = 32'(ext_im_src);
    if (SignX && ext_re_src[Eb-1]) ext_re = ext_re | ~((32'd1 << Eb) - 32'd1);
    if (SignX && ext_im_src[Eb-1]) ext_im = ext_im | ~((32'd1 << Eb) - 32'd1);
  end

  logic idx_ok;
  assign idx_ok = (32'(in_data_i.sample_index) < Depth);

  // sequencer: next state, counters and datapath control
  always_comb begin
    state_d     = state_q;
    sat_d       = sat_q;
    dim_d       = dim_q;
    line_d      = line_q;
    i_d         = i_q;
    k_d         = k_q;
    s_d         = s_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    oob_d       = oob_q;
    a_d         = a_q;
    b_d         = b_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    tre_d       = tre_q;
    tim_d       = tim_q;
    wre_d       = wre_q;
    wim_d       = wim_q;
    ram_we      = 1'b0;
    ram_waddr   = elem_addr(dim_q, line_q, pos_p);
    ram_wdata   = a_q;
    ram_raddr   = elem_addr(dim_q, line_q, pos_q);
    unique case (state_q)
      S_IDLE: begin
        ram_waddr = Aw'(in_data_i.sample_index);
        ram_raddr = Aw'(in_data_i.sample_index);
        ram_wdata = {ext_re, ext_im};
        if (in_fire) begin
          unique case (in_data_i.command)
            CMD_WRITE: ram_we = idx_ok;
            CMD_RUN: begin
              sat_d   = 1'b0;
              dim_d   = 1'b0;
              line_d  = '0;
              i_d     = '0;
              state_d = S_PM_CHK;
            end
            CMD_READ: begin
              oob_d   = !idx_ok;
              state_d = S_RD;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        out_valid_d                = 1'b1;
        out_data_d.result_real     = oob_q ? 32'sd0 : $signed(ram_rdata[63:32]);
        out_data_d.result_imag     = oob_q ? 32'sd0 : $signed(ram_rdata[31:0]);
        out_data_d.run_done        = 1'b0;
        out_data_d.overflow_seen   = sat_q;
        state_d                    = S_IDLE;
      end
      S_PM_CHK, S_PM_WQ: begin
        ram_raddr = elem_addr(dim_q, line_q, i_q);
        ram_waddr = elem_addr(dim_q, line_q, rev_i);
        ram_we    = (state_q == S_PM_WQ);
        if (state_q == S_PM_CHK && i_q < rev_i) begin
          state_d = S_PM_RDQ;
        end else if (i_q == pos_mask) begin
          s_d     = '0;
          k_d     = '0;
          state_d = S_BF_RDQ;
        end else begin
          i_d     = i_q + Pw'(1);
          state_d = S_PM_CHK;
        end
      end
      S_PM_RDQ: begin
        a_d       = ram_rdata;
        ram_raddr = elem_addr(dim_q, line_q, rev_i);
        state_d   = S_PM_WP;
      end
      S_PM_WP: begin
        ram_we    = 1'b1;
        ram_waddr = elem_addr(dim_q, line_q, i_q);
        ram_wdata = ram_rdata;
        state_d   = S_PM_WQ;
      end
      S_BF_RDQ: begin
        wre_d   = tw_c;
        wim_d   = inv_q ? (17'sd0 - tw_s) : tw_s;
        state_d = S_BF_RDP;
      end
      S_BF_RDP: begin
        b_d       = ram_rdata;
        ram_raddr = elem_addr(dim_q, line_q, pos_p);
        state_d   = S_BF_M0;
      end
      S_BF_M0: begin
        a_d     = ram_rdata;
        prod_d  = 49'($signed(b_q[63:32]) * wre_q);
        state_d = S_BF_M1;
      end
      S_BF_M1: begin
        acc_d   = rnd;
        prod_d  = 49'($signed(b_q[31:0]) * wim_q);
        state_d = S_BF_M2;
      end
      S_BF_M2: begin
        tre_d   = sat32(t_full_re);
        sat_d   = sat_q | ovf32(t_full_re);
        prod_d  = 49'($signed(b_q[31:0]) * wre_q);
        state_d = S_BF_M3;
      end
      S_BF_M3: begin
        acc_d   = rnd;
        prod_d  = 49'($signed(b_q[63:32]) * wim_q);
        state_d = S_BF_M4;
      end
      S_BF_M4: begin
        tim_d   = sat32(t_full_im);
        sat_d   = sat_q | ovf32(t_full_im);
        state_d = S_BF_WQ;
      end
      S_BF_WQ: begin
        ram_we    = 1'b1;
        ram_waddr = elem_addr(dim_q, line_q, pos_q);
        ram_wdata = {sat32(dif_re), sat32(dif_im)};
        sat_d     = sat_q | ovf32(dif_re) | ovf32(dif_im);
        state_d   = S_BF_WP;
      end
      S_BF_WP: begin
        ram_we    = 1'b1;
        ram_wdata = {sat32(sum_re), sat32(sum_im)};
        sat_d     = sat_q | ovf32(sum_re) | ovf32(sum_im);
        state_d   = S_BF_RDQ;
        if (k_q != (pos_mask >> 1)) begin
          k_d = k_q + Pw'(1);
        end else if (s_q != cur_bits - Sw'(1)) begin
          s_d = s_q + Sw'(1);
          k_d = '0;
        end else if (line_q != line_last) begin
          line_d  = line_q + Pw'(1);
          i_d     = '0;
          state_d = S_PM_CHK;
        end else if (!dim_q) begin
          dim_d   = 1'b1;
          line_d  = '0;
          i_d     = '0;
          state_d = S_PM_CHK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q) begin
          out_valid_d              = 1'b1;
          out_data_d.result_real   = 32'sd0;
          out_data_d.result_imag   = 32'sd0;
          out_data_d.run_done      = 1'b1;
          out_data_d.overflow_seen = sat_q;
          state_d                  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      inv_q       <= 1'b0;
      sat_q       <= 1'b0;
      dim_q       <= 1'b0;
      line_q      <= '0;
      i_q         <= '0;
      k_q         <= '0;
      s_q         <= '0;
      out_valid_q <= 1'b0;
      oob_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) inv_q <= cfg_wdata_i;
      sat_q       <= sat_d;
      dim_q       <= dim_d;
      line_q      <= line_d;
      i_q         <= i_d;
      k_q         <= k_d;
      s_q         <= s_d;
      out_valid_q <= out_valid_d;
      oob_q       <= oob_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    a_q        <= a_d;
    b_q        <= b_d;
    prod_q     <= prod_d;
    acc_q      <= acc_d;
    tre_q      <= tre_d;
    tim_q      <= tim_d;
    wre_q      <= wre_d;
    wim_q      <= wim_d;
  end

  // checks
  a_run_clears_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.command == CMD_RUN) |=> !sat_q && !in_ready_o)
    else $error("run start did not clear flag or block input");

  a_idle_write_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && ram_we) |-> (in_fire && in_data_i.command == CMD_WRITE))
    else $error("store written while idle without a write item");

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.run_done) |->
      (out_data_o.result_real == 32'sd0 && out_data_o.result_imag == 32'sd0))
    else $error("run answer carries nonzero data");

  a_read_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.command == CMD_READ) |=> ##1 (out_valid_o && !out_data_o.run_done))
    else $error("read item gave no answer");

endmodule

FILE: tb/fft_2d_radix2_inplace_test.sv
// ----------------------------------------------------------------------------
// fft_2d_radix2_inplace_test
// Self-checking bench for the in-place 2-D radix-2 FFT: directed items, then a
// full store fill, transforms under both twiddle signs and random reads/writes,
// with each result checked against literal values or a fixed-point FFT predictor.
// ----------------------------------------------------------------------------
module fft_2d_radix2_inplace_test;
  import fft2d_pkg::*;

  localparam int NR    = DefRows;
  localparam int NC    = DefCols;
  localparam int NTOT  = NR * NC;
  localparam int LIMIT = 4000000;

  typedef struct {
    cmd_e        cmd;
    int          idx;
    int          re;
    int          im;
    bit          lit;
    out_item_t   want;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we;
  logic      cfg_wdata;
  logic      in_valid;
  logic      in_ready_o;
  in_item_t  in_data;
  logic      out_valid_o;
  logic      out_ready;
  out_item_t out_data_o;

  // predictor state
  longint    fft_re [NTOT];
  longint    fft_im [NTOT];
  bit        written [NTOT];
  bit        sat_flag;
  bit        twiddle_sign;
  longint    sine_q [0:256];

  out_item_t expected_q [$];
  int        fail_count;
  int        send_idle;
  int        recv_stall;
  longint    cycles;

  fft_2d_radix2_inplace dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // quarter-wave sine table, Q2.30 series rounded to Q1.15
  function automatic void fill_sine();
    longint unsigned x, x2, term;
    longint          sum, q;
    for (int k = 0; k <= 256; k++) begin
      x    = (longint'(k) * 64'd1686629713 + 64'd128) / 64'd256;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      q = (sum + 16384) >>> 15;
      if (q > 32767) q = 32767;
      sine_q[k] = q;
    end
  endfunction

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) begin
      sat_flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat_flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // floor((p + 16384) / 32768)
  function automatic longint round15(input longint p);
    return (p + 16384) >>> 15;
  endfunction

  // bit reversal then radix-2 stages on one row or column
  function automatic void transform_line(input int base, input int stride, input int n);
    int     bits, r, t, p, q, m, step, k;
    longint tr, ti, wr, wi, ar, ai, br, bi;
    bits = $clog2(n);
    for (int i = 0; i < n; i++) begin
      r = 0;
      t = i;
      for (int b = 0; b < bits; b++) begin
        r = (r << 1) | (t & 1);
        t = t >> 1;
      end
      if (i < r) begin
        p = base + i * stride;
        q = base + r * stride;
        tr = fft_re[p]; ti = fft_im[p];
        fft_re[p] = fft_re[q]; fft_im[p] = fft_im[q];
        fft_re[q] = tr; fft_im[q] = ti;
      end
    end
    for (int half = 1; half < n; half = half << 1) begin
      m    = half << 1;
      step = 1024 / m;
      for (int j = 0; j < half; j++) begin
        k = (j * step) & 511;
        if (k <= 256) begin
          wr = sine_q[256 - k];
          wi = sine_q[k];
        end else begin
          wr = -sine_q[k - 256];
          wi = sine_q[512 - k];
        end
        if (twiddle_sign) wi = -wi;
        for (int g = 0; g < n; g += m) begin
          p  = base + (g + j) * stride;
          q  = base + (g + j + half) * stride;
          br = fft_re[q]; bi = fft_im[q];
          ar = fft_re[p]; ai = fft_im[p];
          tr = clip32(round15(wr * br) - round15(wi * bi));
          ti = clip32(round15(wr * bi) + round15(wi * br));
          fft_re[q] = clip32(ar - tr);
          fft_im[q] = clip32(ai - ti);
          fft_re[p] = clip32(ar + tr);
          fft_im[p] = clip32(ai + ti);
        end
      end
    end
  endfunction

  // applies one item to the predictor and gives its answer, if any
  function automatic void model_item(input in_item_t it, output bit has, output out_item_t res);
    int idx;
    idx = int'(it.sample_index);
    has = 1'b0;
    res = '0;
    case (it.command)
      CMD_WRITE: begin
        if (idx < NTOT) begin
          fft_re[idx]  = longint'(it.sample_real);
          fft_im[idx]  = longint'(it.sample_imag);
          written[idx] = 1'b1;
        end
      end
      CMD_RUN: begin
        sat_flag = 1'b0;
        for (int r = 0; r < NR; r++) transform_line(r * NC, 1, NC);
        for (int c = 0; c < NC; c++) transform_line(c, NC, NR);
        has               = 1'b1;
        res.run_done      = 1'b1;
        res.overflow_seen = sat_flag;
      end
      CMD_READ: begin
        has = 1'b1;
        if (idx < NTOT) begin
          res.result_real = 32'(fft_re[idx]);
          res.result_imag = 32'(fft_im[idx]);
        end
        res.overflow_seen = sat_flag;
      end
      default: ;
    endcase
  endfunction

  // drive one item and wait for its acceptance
  task automatic push_item(input in_item_t it, input bit lit, input out_item_t want);
    bit        has;
    out_item_t res;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    model_item(it, has, res);
    if (has) expected_q.push_back(lit ? want : res);
    @(negedge clk_i);
  endtask

  task automatic send_cmd(input cmd_e cmd, input int idx, input int re, input int im);
    in_item_t it;
    it.command      = cmd;
    it.sample_index = 12'(idx);
    it.sample_real  = 16'(re);
    it.sample_imag  = 16'(im);
    push_item(it, 1'b0, '0);
  endtask

  // wait for all answers, then let a write settle
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_sign(input bit v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we       <= 1'b0;
    twiddle_sign = v;
  endtask

  task automatic set_phase(input int ph);
    case (ph % 4)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 86; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 86; end
      default: begin send_idle = 19; recv_stall = 19; end
    endcase
  endtask

  task automatic random_reads(input int n);
    int i;
    for (int k = 0; k < n; k++) begin
      i = $urandom_range(NTOT - 1);
      if (written[i]) send_cmd(CMD_READ, i, 0, 0);
    end
  endtask

  task automatic report(input string name, input longint want, input longint got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    fail_count++;
  endtask

  // receiver stalls
  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // result checking
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data_o);
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        if (out_data_o.result_real !== e.result_real)
          report("result_real", e.result_real, out_data_o.result_real);
        if (out_data_o.result_imag !== e.result_imag)
          report("result_imag", e.result_imag, out_data_o.result_imag);
        if (out_data_o.run_done !== e.run_done)
          report("run_done", e.run_done, out_data_o.run_done);
        if (out_data_o.overflow_seen !== e.overflow_seen)
          report("overflow_seen", e.overflow_seen, out_data_o.overflow_seen);
      end
    end
  end

  // stimulus
  initial begin
    dir_row_t  dir_table [$];
    dir_row_t  row;
    in_item_t  it;
    out_item_t w;
    int        idx;

    rst_ni     = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    cycles     = 0;
    fail_count = 0;
    sat_flag   = 1'b0;
    twiddle_sign = 1'b0;
    send_idle  = 0;
    recv_stall = 0;
    fill_sine();
    for (int i = 0; i < NTOT; i++) begin
      fft_re[i] = 0; fft_im[i] = 0; written[i] = 1'b0;
    end

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed items: extremes, unused command, reads back of written values
    w = '0;
    dir_table.push_back('{CMD_WRITE, 0, 32767, -32768, 1'b0, w});
    dir_table.push_back('{CMD_WRITE, NTOT - 1, -32768, 32767, 1'b0, w});
    dir_table.push_back('{CMD_WRITE, 1, 0, 0, 1'b0, w});
    dir_table.push_back('{CMD_WRITE, 2, -1, 1, 1'b0, w});
    dir_table.push_back('{CMD_NONE, 3, 1234, -1234, 1'b0, w});
    w = '0; w.result_real = 32767; w.result_imag = -32768;
    dir_table.push_back('{CMD_READ, 0, 0, 0, 1'b1, w});
    w = '0; w.result_real = -32768; w.result_imag = 32767;
    dir_table.push_back('{CMD_READ, NTOT - 1, 0, 0, 1'b1, w});
    w = '0;
    dir_table.push_back('{CMD_READ, 1, 0, 0, 1'b1, w});
    w = '0; w.result_real = -1; w.result_imag = 1;
    dir_table.push_back('{CMD_READ, 2, 0, 0, 1'b1, w});
    dir_table.push_back('{CMD_WRITE, 0, 21845, -21846, 1'b0, w});
    dir_table.push_back('{CMD_READ, 0, 0, 0, 1'b0, w});
    dir_table.push_back('{CMD_READ, 0, 0, 0, 1'b0, w});
    dir_table.push_back('{CMD_NONE, NTOT - 1, 0, 0, 1'b0, w});
    dir_table.push_back('{CMD_READ, NTOT - 1, 0, 0, 1'b0, w});

    set_sign(1'b0);
    foreach (dir_table[k]) begin
      row = dir_table[k];
      it.command      = row.cmd;
      it.sample_index = 12'(row.idx);
      it.sample_real  = 16'(row.re);
      it.sample_imag  = 16'(row.im);
      push_item(it, row.lit, row.want);
    end
    drain();

    // fill the whole store, with reads and unused commands mixed in
    for (int i = 0; i < NTOT; i++) begin
      if (i % 512 == 0) set_phase(i / 512);
      send_cmd(CMD_WRITE, i, int'($urandom_range(65535)), int'($urandom_range(65535)));
      case ($urandom_range(15))
        0: random_reads(1);
        1: send_cmd(CMD_NONE, $urandom_range(NTOT - 1), $urandom, $urandom);
        default: ;
      endcase
    end

    // transforms under each twiddle sign, repeated runs drive saturation
    for (int pass = 0; pass < 3; pass++) begin
      drain();
      set_sign(pass == 1);
      set_phase(pass);
      send_cmd(CMD_RUN, $urandom_range(NTOT - 1), 0, 0);
      for (int k = 0; k < 120; k++) begin
        if (k % 30 == 0) set_phase(pass + k / 30);
        idx = $urandom_range(NTOT - 1);
        case ($urandom_range(3))
          0: send_cmd(CMD_WRITE, idx, int'($urandom_range(65535)),
                      int'($urandom_range(65535)));
          1: send_cmd(CMD_NONE, idx, $urandom, $urandom);
          default: send_cmd(CMD_READ, idx, $urandom, $urandom);
        endcase
      end
    end

    drain();
    repeat (50) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
